// ===== rtl/core/osc133_mark_parser_assert.svh =====
// Assertion macros shared by the checkers of the mark parser.
`ifndef OSC133_MARK_PARSER_ASSERT_SVH
`define OSC133_MARK_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/omp_pkg.sv =====
package omp_pkg;

    // Longest accepted number text is one byte less than this limit.
    localparam int NUMBER_TEXT_LIMIT = 16;
    localparam int CNT_W = $clog2(NUMBER_TEXT_LIMIT + 1);

    // Mark kinds as they appear on the result channel.
    localparam logic [2:0] KIND_A = 3'd0;
    localparam logic [2:0] KIND_B = 3'd1;
    localparam logic [2:0] KIND_C = 3'd2;
    localparam logic [2:0] KIND_D = 3'd3;
    localparam logic [2:0] KIND_R = 3'd4;

    // Bytes of interest in the stream.
    localparam logic [7:0] BYTE_ESC  = 8'h1B;
    localparam logic [7:0] BYTE_BEL  = 8'h07;
    localparam logic [7:0] BYTE_BSL  = 8'h5C;
    localparam logic [7:0] BYTE_SEMI = 8'h3B;
    localparam logic [7:0] BYTE_RBR  = 8'h5D;
    localparam logic [7:0] BYTE_ONE  = 8'h31;
    localparam logic [7:0] BYTE_THR  = 8'h33;
    localparam logic [7:0] BYTE_PLUS = 8'h2B;
    localparam logic [7:0] BYTE_MIN  = 8'h2D;
    localparam logic [7:0] BYTE_SPC  = 8'h20;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_ZERO = 8'h30;
    localparam logic [7:0] BYTE_NINE = 8'h39;
    localparam logic [7:0] BYTE_UA   = 8'h41;
    localparam logic [7:0] BYTE_UB   = 8'h42;
    localparam logic [7:0] BYTE_UC   = 8'h43;
    localparam logic [7:0] BYTE_UD   = 8'h44;
    localparam logic [7:0] BYTE_UR   = 8'h52;

    localparam logic [31:0] CODE_NONE = 32'hFFFF_FFFF;

    // Parser phase: prefix bytes seen, then type byte, then parameters.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ESC,
        PH_BRACKET,
        PH_ONE,
        PH_THREE,
        PH_THREE2,
        PH_TYPE,
        PH_FIRST,
        PH_PARAMS
    } phase_t;

    // Number reader: skipping whitespace, reading digits, finished.
    typedef enum logic [1:0] {
        NS_SPACE,
        NS_DIGITS,
        NS_DONE
    } num_stage_t;

    // One step result from the parser core.
    typedef struct packed {
        logic        hit;
        logic [2:0]  kind;
        logic [31:0] code;
    } omp_result_t;

endpackage

// ===== rtl/core/omp_core.sv =====
module omp_core
    import omp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output omp_result_t result
);

    phase_t           phase_reg, phase_next;
    logic [2:0]       kind_reg, kind_next;
    logic             known_reg, known_next;
    logic             escp_reg, escp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             semi_reg, semi_next;
    num_stage_t       stage_reg, stage_next;
    logic             neg_reg, neg_next;
    logic [31:0]      val_reg, val_next;

    // Byte that must follow in each prefix phase.
    function automatic logic [7:0] prefix_expect(input phase_t p);
        logic [7:0] b;
        case (p)
            PH_ESC:     b = BYTE_RBR;
            PH_BRACKET: b = BYTE_ONE;
            PH_ONE:     b = BYTE_THR;
            PH_THREE:   b = BYTE_THR;
            default:    b = BYTE_SEMI;
        endcase
        return b;
    endfunction

    // Phase reached when the expected prefix byte arrives.
    function automatic phase_t prefix_follow(input phase_t p);
        phase_t n;
        case (p)
            PH_ESC:     n = PH_BRACKET;
            PH_BRACKET: n = PH_ONE;
            PH_ONE:     n = PH_THREE;
            PH_THREE:   n = PH_THREE2;
            default:    n = PH_TYPE;
        endcase
        return n;
    endfunction

    // Saturating increment of the number text length.
    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_W'(NUMBER_TEXT_LIMIT)) ? c : c + CNT_W'(1);
    endfunction

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_A;
            known_reg <= 1'b0;
            escp_reg  <= 1'b0;
            cnt_reg   <= '0;
            semi_reg  <= 1'b0;
            stage_reg <= NS_SPACE;
            neg_reg   <= 1'b0;
            val_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            known_reg <= known_next;
            escp_reg  <= escp_next;
            cnt_reg   <= cnt_next;
            semi_reg  <= semi_next;
            stage_reg <= stage_next;
            neg_reg   <= neg_next;
            val_reg   <= val_next;
        end
    end

    // Next state and result for the byte in hand.
    always_comb
    begin
        logic fin;
        logic is_space;
        logic is_digit;
        logic code_ok;

        phase_next = phase_reg;
        kind_next  = kind_reg;
        known_next = known_reg;
        escp_next  = escp_reg;
        cnt_next   = cnt_reg;
        semi_next  = semi_reg;
        stage_next = stage_reg;
        neg_next   = neg_reg;
        val_next   = val_reg;
        fin        = 1'b0;
        is_space   = (data_byte == BYTE_SPC) ||
                     ((data_byte >= BYTE_TAB) && (data_byte <= BYTE_CR));
        is_digit   = (data_byte >= BYTE_ZERO) && (data_byte <= BYTE_NINE);

        case (phase_reg)
            PH_IDLE:
            begin
                if (data_byte == BYTE_ESC)
                    phase_next = PH_ESC;
            end
            PH_ESC, PH_BRACKET, PH_ONE, PH_THREE, PH_THREE2:
            begin
                // A mismatching ESC restarts the prefix at once.
                if (data_byte == prefix_expect(phase_reg))
                    phase_next = prefix_follow(phase_reg);
                else if (data_byte == BYTE_ESC)
                    phase_next = PH_ESC;
                else
                    phase_next = PH_IDLE;
            end
            PH_TYPE:
            begin
                known_next = 1'b1;
                case (data_byte)
                    BYTE_UA: kind_next = KIND_A;
                    BYTE_UB: kind_next = KIND_B;
                    BYTE_UC: kind_next = KIND_C;
                    BYTE_UD: kind_next = KIND_D;
                    BYTE_UR: kind_next = KIND_R;
                    default:
                    begin
                        kind_next  = KIND_A;
                        known_next = 1'b0;
                    end
                endcase
                phase_next = PH_FIRST;
            end
            PH_FIRST, PH_PARAMS:
            begin
                phase_next = PH_PARAMS;
                if (escp_reg && (data_byte == BYTE_BSL))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    escp_next = 1'b0;
                    // A lone ESC is one text byte that ends the number.
                    if (escp_reg && semi_reg)
                    begin
                        cnt_next   = cnt_inc(cnt_next);
                        stage_next = NS_DONE;
                    end
                    if (data_byte == BYTE_BEL)
                        fin = 1'b1;
                    else if (data_byte == BYTE_ESC)
                        escp_next = 1'b1;
                    else if ((phase_reg == PH_FIRST) && (data_byte == BYTE_SEMI))
                        semi_next = 1'b1;
                    else if (semi_next)
                    begin
                        // Number text: whitespace, optional sign, digits.
                        cnt_next = cnt_inc(cnt_next);
                        if (stage_next == NS_SPACE)
                        begin
                            if (!is_space)
                            begin
                                stage_next = NS_DIGITS;
                                if ((data_byte == BYTE_PLUS) || (data_byte == BYTE_MIN))
                                    neg_next = (data_byte == BYTE_MIN);
                                else if (is_digit)
                                    val_next = {28'd0, data_byte[3:0]};
                                else
                                    stage_next = NS_DONE;
                            end
                        end
                        else if (stage_next == NS_DIGITS)
                        begin
                            if (is_digit)
                                val_next = (val_next << 3) + (val_next << 1) +
                                           {28'd0, data_byte[3:0]};
                            else
                                stage_next = NS_DONE;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Exit code is valid only for D with a well-sized number text.
        code_ok = (kind_next == KIND_D) && semi_next && (cnt_next != '0) &&
                  (cnt_next < CNT_W'(NUMBER_TEXT_LIMIT));
        result.hit  = fin && known_next;
        result.kind = kind_next;
        result.code = code_ok ? (neg_next ? (32'd0 - val_next) : val_next) : CODE_NONE;

        // A terminator or the end of a buffer drops all sequence state.
        if (fin || buffer_end)
        begin
            phase_next = PH_IDLE;
            kind_next  = KIND_A;
            known_next = 1'b0;
            escp_next  = 1'b0;
            cnt_next   = '0;
            semi_next  = 1'b0;
            stage_next = NS_SPACE;
            neg_next   = 1'b0;
            val_next   = '0;
        end
    end

endmodule

// ===== rtl/core/osc133_mark_parser.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_stall   data_byte[7:0], buffer_end
// result    out_valid / out_stall mark_kind[2:0], status_code[31:0] signed
//
// One byte is taken every cycle while in_stall is low.
// The input register feeds the parser state and the result register in one step.
// Reset clears the parser to idle and empties both registers.
// in_stall rises only while a result waits in the output register under out_stall.
module osc133_mark_parser
    import omp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               buffer_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         mark_kind,
    output logic signed [31:0] status_code
);

    logic               in_vld_reg;
    logic [7:0]         byte_reg;
    logic               end_reg;
    logic               out_vld_reg, out_vld_next;
    logic [2:0]         kind_reg;
    logic signed [31:0] code_reg;
    logic               advance;
    logic               step;
    omp_result_t        result;

    // The step runs when the output register is free or being drained.
    assign advance  = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            end_reg  <= buffer_end;
        end
    end

    omp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (byte_reg),
        .buffer_end (end_reg),
        .result     (result)
    );

    // Result register.
    assign out_vld_next = advance ? (step && result.hit) : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && result.hit)
        begin
            kind_reg <= result.kind;
            code_reg <= result.code;
        end
    end

    assign out_valid   = out_vld_reg;
    assign mark_kind   = kind_reg;
    assign status_code = code_reg;

endmodule

// ===== rtl/core/omp_checker.sv =====
`include "osc133_mark_parser_assert.svh"

module omp_checker
    import omp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  mark_kind,
    input logic [31:0] status_code
);

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // A waiting result holds until its transfer.
    `OMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(mark_kind) && $stable(status_code), "result changed while stalled")

    // Only D marks carry an exit code.
    `OMP_ASSERT_NOW(a_code_none, out_valid && (mark_kind != KIND_D),
        status_code == CODE_NONE, "non-D mark with an exit code")

    // The input side stalls only behind a stalled result.
    `OMP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled without a waiting result")

    // A fresh result follows an input transfer through the input register.
    `OMP_ASSERT_NOW(a_out_source, $rose(out_valid), $past(in_xfer, 2),
        "result without a preceding input transfer")

endmodule

bind osc133_mark_parser omp_checker u_omp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mark_kind   (mark_kind),
    .status_code (status_code)
);
